// ===== sv/texture_bleed_distance_fill_top_macros.svh =====
// Assertion macros for the texture bleed fill block.
// Depends on nothing; included by the top level.
`ifndef TEXTURE_BLEED_DISTANCE_FILL_TOP_MACROS_SVH
`define TEXTURE_BLEED_DISTANCE_FILL_TOP_MACROS_SVH

`define TBDF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbdf: lbl failed");

`define TBDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbdf: lbl failed");

`endif

// ===== sv/tbdf_pkg.sv =====
// Shared types, constants and helper functions of the texture bleed fill block.
// Depends on nothing; used by every module of the block but tbdf_ram.
package tbdf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int DIM_W      = 9;
  localparam int CW         = DIM_W + 2;
  localparam int D_W        = ((X_W > Y_W) ? X_W : Y_W) + 1;
  localparam int SQ_W       = 2 * (D_W + 1) + 1;
  localparam int PIX_W      = 32;
  localparam int OFF_W      = 2 * D_W + 1;
  localparam int CFG_AW     = 4;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(MAX_HEIGHT);
  localparam logic [7:0]       THRESH_RESET = 8'd20;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef enum logic [2:0] {
    PH_INIT, PH_FWD_A, PH_FWD_B, PH_BWD_A, PH_BWD_B, PH_FILL
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT_RD, S_INIT_WR, S_TRY_NB, S_TRY_ME, S_TRY_SQ, S_TRY_WR,
    S_FILL_RD, S_FILL_CHK, S_FILL_SRC, S_FILL_WR
  } state_t;

  typedef struct packed {
    logic       func;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    logic                  valid;
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
  } off_t;

  typedef struct packed {
    logic   load;
    logic   fetch;
    phase_t phase;
    phase_t new_phase;
    logic   frame_init;
    logic   row_init;
    logic   adv_y;
    logic   adv_x;
    logic   adv_k;
    logic   pix_rd_src;
    logic   off_rd_nb;
    logic   init_wr;
    logic   cap_nb;
    logic   cap_me;
    logic   try_wr;
    logic   fill_chk;
    logic   fill_wr;
  } cmd_t;

  typedef struct packed {
    logic sweep_go;
    logic nb_in;
    logic fill_go;
    logic k_last;
    logic x_last;
    logic y_last;
  } stat_t;

  function automatic logic ph_asc_x(phase_t ph);
    return !(ph == PH_FWD_B || ph == PH_BWD_A);
  endfunction

  function automatic logic ph_asc_y(phase_t ph);
    return !(ph == PH_BWD_A || ph == PH_BWD_B);
  endfunction

  function automatic logic [1:0] ph_k_last(phase_t ph);
    return (ph == PH_FWD_A || ph == PH_BWD_A) ? 2'd3 : 2'd0;
  endfunction

  function automatic logic signed [1:0] nbr_ox(phase_t ph, logic [1:0] k);
    logic signed [1:0] r;
    r = 2'sd0;
    case (ph)
      PH_FWD_A: r = (k == 2'd1) ? 2'sd0 : ((k == 2'd3) ? 2'sd1 : -2'sd1);
      PH_FWD_B: r = 2'sd1;
      PH_BWD_A: r = (k == 2'd1) ? 2'sd0 : ((k == 2'd2) ? -2'sd1 : 2'sd1);
      PH_BWD_B: r = -2'sd1;
      default:  r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] nbr_oy(phase_t ph, logic [1:0] k);
    logic signed [1:0] r;
    r = 2'sd0;
    case (ph)
      PH_FWD_A: r = (k == 2'd0) ? 2'sd0 : -2'sd1;
      PH_BWD_A: r = (k == 2'd0) ? 2'sd0 : 2'sd1;
      default:  r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/tbdf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module tbdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tbdf_ctrl.sv =====
// Sequencer of the texture bleed fill block: handshake and the sweep passes.
// Depends on tbdf_pkg.
module tbdf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            func,
  input  tbdf_pkg::stat_t stat,
  output tbdf_pkg::cmd_t  cmd,
  output logic            busy
);

  tbdf_pkg::state_t state, state_next;
  tbdf_pkg::phase_t phase, phase_next;

  function automatic tbdf_pkg::state_t first_state(tbdf_pkg::phase_t ph);
    tbdf_pkg::state_t s;
    s = tbdf_pkg::S_TRY_NB;
    if (ph == tbdf_pkg::PH_INIT) begin
      s = tbdf_pkg::S_INIT_RD;
    end else if (ph == tbdf_pkg::PH_FILL) begin
      s = tbdf_pkg::S_FILL_RD;
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbdf_pkg::S_IDLE;
      phase <= tbdf_pkg::PH_INIT;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign busy = (state != tbdf_pkg::S_IDLE);

  always_comb begin
    logic adv;
    adv = 1'b0;
    cmd = '0;
    cmd.phase = phase;
    cmd.new_phase = phase;
    state_next = state;
    phase_next = phase;
    unique case (state)
      tbdf_pkg::S_IDLE: begin
        cmd.load  = start && (func == tbdf_pkg::FUNC_LOAD);
        cmd.fetch = start && (func == tbdf_pkg::FUNC_FETCH);
        if (cmd.load && stat.sweep_go) begin
          cmd.frame_init = 1'b1;
          cmd.new_phase  = tbdf_pkg::PH_INIT;
          phase_next     = tbdf_pkg::PH_INIT;
          state_next     = tbdf_pkg::S_INIT_RD;
        end
      end
      tbdf_pkg::S_INIT_RD:  state_next = tbdf_pkg::S_INIT_WR;
      tbdf_pkg::S_INIT_WR: begin
        cmd.init_wr = 1'b1;
        adv = 1'b1;
      end
      tbdf_pkg::S_TRY_NB: begin
        if (stat.nb_in) begin
          cmd.off_rd_nb = 1'b1;
          state_next = tbdf_pkg::S_TRY_ME;
        end else begin
          adv = 1'b1;
        end
      end
      tbdf_pkg::S_TRY_ME: begin
        cmd.cap_nb = 1'b1;
        state_next = tbdf_pkg::S_TRY_SQ;
      end
      tbdf_pkg::S_TRY_SQ: begin
        cmd.cap_me = 1'b1;
        state_next = tbdf_pkg::S_TRY_WR;
      end
      tbdf_pkg::S_TRY_WR: begin
        cmd.try_wr = 1'b1;
        adv = 1'b1;
      end
      tbdf_pkg::S_FILL_RD:  state_next = tbdf_pkg::S_FILL_CHK;
      tbdf_pkg::S_FILL_CHK: begin
        cmd.fill_chk = 1'b1;
        if (stat.fill_go) begin
          state_next = tbdf_pkg::S_FILL_SRC;
        end else begin
          adv = 1'b1;
        end
      end
      tbdf_pkg::S_FILL_SRC: begin
        cmd.pix_rd_src = 1'b1;
        state_next = tbdf_pkg::S_FILL_WR;
      end
      tbdf_pkg::S_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        adv = 1'b1;
      end
      default: state_next = tbdf_pkg::S_IDLE;
    endcase

    if (adv) begin
      if (!stat.k_last) begin
        cmd.adv_k = 1'b1;
        state_next = tbdf_pkg::S_TRY_NB;
      end else if (!stat.x_last) begin
        cmd.adv_x = 1'b1;
        state_next = first_state(phase);
      end else if (phase == tbdf_pkg::PH_FWD_A || phase == tbdf_pkg::PH_BWD_A) begin
        cmd.row_init = 1'b1;
        cmd.new_phase = (phase == tbdf_pkg::PH_FWD_A) ? tbdf_pkg::PH_FWD_B
                                                      : tbdf_pkg::PH_BWD_B;
        phase_next = cmd.new_phase;
        state_next = tbdf_pkg::S_TRY_NB;
      end else if (!stat.y_last) begin
        cmd.adv_y = 1'b1;
        unique case (phase)
          tbdf_pkg::PH_FWD_B: cmd.new_phase = tbdf_pkg::PH_FWD_A;
          tbdf_pkg::PH_BWD_B: cmd.new_phase = tbdf_pkg::PH_BWD_A;
          default:            cmd.new_phase = phase;
        endcase
        phase_next = cmd.new_phase;
        state_next = first_state(cmd.new_phase);
      end else begin
        unique case (phase)
          tbdf_pkg::PH_INIT: begin
            cmd.frame_init = 1'b1;
            cmd.new_phase = tbdf_pkg::PH_FWD_A;
            phase_next = tbdf_pkg::PH_FWD_A;
            state_next = tbdf_pkg::S_TRY_NB;
          end
          tbdf_pkg::PH_FWD_B: begin
            cmd.frame_init = 1'b1;
            cmd.new_phase = tbdf_pkg::PH_BWD_A;
            phase_next = tbdf_pkg::PH_BWD_A;
            state_next = tbdf_pkg::S_TRY_NB;
          end
          tbdf_pkg::PH_BWD_B: begin
            cmd.frame_init = 1'b1;
            cmd.new_phase = tbdf_pkg::PH_FILL;
            phase_next = tbdf_pkg::PH_FILL;
            state_next = tbdf_pkg::S_FILL_RD;
          end
          default: state_next = tbdf_pkg::S_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== sv/tbdf_datapath.sv =====
// Datapath of the texture bleed fill block: counters, scan position, stores
// and the distance arithmetic. Depends on tbdf_pkg and tbdf_ram.
module tbdf_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  tbdf_pkg::cmd_t                 cmd,
  output tbdf_pkg::stat_t                stat,
  input  tbdf_pkg::in_item_t             item,
  input  logic [tbdf_pkg::DIM_W-1:0]     cfg_width,
  input  logic [tbdf_pkg::DIM_W-1:0]     cfg_height,
  input  logic [7:0]                     cfg_thresh,
  input  logic                           cfg_clear,
  output tbdf_pkg::out_item_t            result,
  output logic                           done
);

  localparam int AW = tbdf_pkg::ADDR_W;
  localparam int NW = tbdf_pkg::CNT_W;
  localparam int CW = tbdf_pkg::CW;
  localparam int DW = tbdf_pkg::D_W;
  localparam int SW = tbdf_pkg::SQ_W;

  logic [tbdf_pkg::DIM_W-1:0] w_eff, h_eff;
  logic [NW-1:0] total, load_count, read_count, lc_eff, rc_eff, rc_inc;
  logic any_solid, wrap, solid, fetch_ok, last_pixel;
  logic [tbdf_pkg::X_W-1:0] x, xs, w1;
  logic [tbdf_pkg::Y_W-1:0] y, ys, h1;
  logic [1:0] k;
  logic [AW-1:0] me, base, base_n, nb_addr, src;
  logic signed [1:0] ox, oy;
  logic signed [CW-1:0] nx, ny, sx, sy, wsg, hsg;
  logic signed [AW+1:0] nb_full, woff, src_full;
  logic [tbdf_pkg::PIX_W-1:0] pix_wdata, pix_rdata;
  logic [AW-1:0] pix_waddr, pix_raddr;
  logic pix_we, off_we;
  tbdf_pkg::off_t off_wdata, off_rdata;
  logic [tbdf_pkg::OFF_W-1:0] off_rbits;
  logic signed [DW:0] cdx_c, cdy_c, cdx, cdy;
  logic [SW-1:0] cd, pd;
  logic nbv, mev;

  assign w_eff = (cfg_width == '0) ? tbdf_pkg::DIM_W'(1) :
                 (cfg_width > tbdf_pkg::DIM_W'(tbdf_pkg::MAX_WIDTH)) ?
                 tbdf_pkg::DIM_W'(tbdf_pkg::MAX_WIDTH) : cfg_width;
  assign h_eff = (cfg_height == '0) ? tbdf_pkg::DIM_W'(1) :
                 (cfg_height > tbdf_pkg::DIM_W'(tbdf_pkg::MAX_HEIGHT)) ?
                 tbdf_pkg::DIM_W'(tbdf_pkg::MAX_HEIGHT) : cfg_height;
  assign total = NW'(w_eff * h_eff);
  assign w1 = tbdf_pkg::X_W'(w_eff - 1'b1);
  assign h1 = tbdf_pkg::Y_W'(h_eff - 1'b1);
  assign wsg = $signed({2'b00, w_eff});
  assign hsg = $signed({2'b00, h_eff});

  assign wrap   = (load_count >= total);
  assign lc_eff = wrap ? '0 : load_count;
  assign solid  = (item.in_alpha > cfg_thresh);
  assign fetch_ok = (load_count >= total);
  assign rc_eff = (read_count >= total) ? '0 : read_count;
  assign rc_inc = rc_eff + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      read_count <= '0;
      any_solid  <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= cmd.fetch && fetch_ok;
      if (cfg_clear) begin
        load_count <= '0;
        read_count <= '0;
        any_solid  <= 1'b0;
      end else if (cmd.load) begin
        load_count <= lc_eff + 1'b1;
        any_solid  <= (any_solid && !wrap) || solid;
        if (wrap) begin
          read_count <= '0;
        end
      end else if (cmd.fetch && fetch_ok) begin
        read_count <= (rc_inc == total) ? '0 : rc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      last_pixel <= (rc_eff == total - 1'b1);
    end
  end

  // Scan position.
  assign xs = tbdf_pkg::ph_asc_x(cmd.new_phase) ? '0 : w1;
  assign ys = tbdf_pkg::ph_asc_y(cmd.new_phase) ? '0 : h1;
  always_comb begin
    base_n = base;
    if (cmd.frame_init) begin
      base_n = tbdf_pkg::ph_asc_y(cmd.new_phase) ? '0 : AW'(total - NW'(w_eff));
    end else if (cmd.adv_y) begin
      base_n = tbdf_pkg::ph_asc_y(cmd.new_phase) ? AW'(base + AW'(w_eff))
                                                  : AW'(base - AW'(w_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_init || cmd.adv_y || cmd.row_init) begin
      x    <= xs;
      k    <= '0;
      base <= base_n;
      me   <= base_n + AW'(xs);
      if (cmd.frame_init) begin
        y <= ys;
      end else if (cmd.adv_y) begin
        y <= tbdf_pkg::ph_asc_y(cmd.new_phase) ? y + 1'b1 : y - 1'b1;
      end
    end else if (cmd.adv_x) begin
      k <= '0;
      if (tbdf_pkg::ph_asc_x(cmd.phase)) begin
        x  <= x + 1'b1;
        me <= me + 1'b1;
      end else begin
        x  <= x - 1'b1;
        me <= me - 1'b1;
      end
    end else if (cmd.adv_k) begin
      k <= k + 1'b1;
    end
  end

  assign stat.k_last = (k == tbdf_pkg::ph_k_last(cmd.phase));
  assign stat.x_last = tbdf_pkg::ph_asc_x(cmd.phase) ? (x == w1) : (x == '0);
  assign stat.y_last = tbdf_pkg::ph_asc_y(cmd.phase) ? (y == h1) : (y == '0);
  assign stat.sweep_go = ((lc_eff + 1'b1) == total) && ((any_solid && !wrap) || solid);

  // Neighbor of the current try.
  assign ox = tbdf_pkg::nbr_ox(cmd.phase, k);
  assign oy = tbdf_pkg::nbr_oy(cmd.phase, k);
  assign nx = $signed(CW'(x)) + CW'(ox);
  assign ny = $signed(CW'(y)) + CW'(oy);
  assign stat.nb_in = (nx >= 0) && (nx < wsg) && (ny >= 0) && (ny < hsg);
  assign woff = (oy == 2'sd1) ? $signed((AW+2)'(w_eff)) :
                (oy == -2'sd1) ? -$signed((AW+2)'(w_eff)) : '0;
  assign nb_full = $signed((AW+2)'(me)) + (AW+2)'(ox) + woff;
  assign nb_addr = nb_full[AW-1:0];

  // Distance arithmetic.
  assign off_rdata = tbdf_pkg::off_t'(off_rbits);
  assign cdx_c = (DW+1)'(off_rdata.dx) + (DW+1)'(ox);
  assign cdy_c = (DW+1)'(off_rdata.dy) + (DW+1)'(oy);

  always_ff @(posedge clk) begin
    if (cmd.cap_nb) begin
      nbv <= off_rdata.valid;
      cdx <= cdx_c;
      cdy <= cdy_c;
      cd  <= SW'(cdx_c * cdx_c) + SW'(cdy_c * cdy_c);
    end
    if (cmd.cap_me) begin
      mev <= off_rdata.valid;
      pd  <= SW'(off_rdata.dx * off_rdata.dx) + SW'(off_rdata.dy * off_rdata.dy);
    end
  end

  // Fill check.
  assign sx = $signed(CW'(x)) + CW'(off_rdata.dx);
  assign sy = $signed(CW'(y)) + CW'(off_rdata.dy);
  assign stat.fill_go = (pix_rdata[31:24] == 8'h00) && off_rdata.valid &&
                        (sx >= 0) && (sx < wsg) && (sy >= 0) && (sy < hsg);
  assign src_full = $signed((AW+2)'(me)) + (AW+2)'(off_rdata.dx) +
                    (AW+2)'(off_rdata.dy * $signed({1'b0, w_eff}));

  always_ff @(posedge clk) begin
    if (cmd.fill_chk) begin
      src <= src_full[AW-1:0];
    end
  end

  // Store ports.
  assign pix_we    = cmd.load || cmd.fill_wr;
  assign pix_waddr = cmd.load ? lc_eff[AW-1:0] : me;
  assign pix_wdata = cmd.load ? {item.in_alpha, item.in_blue, item.in_green, item.in_red}
                              : {8'h00, pix_rdata[23:0]};
  assign pix_raddr = cmd.fetch ? rc_eff[AW-1:0] : (cmd.pix_rd_src ? src : me);

  always_comb begin
    off_wdata = '0;
    if (cmd.init_wr) begin
      off_wdata.valid = (pix_rdata[31:24] > cfg_thresh);
    end else begin
      off_wdata.valid = 1'b1;
      off_wdata.dx = cdx[DW-1:0];
      off_wdata.dy = cdy[DW-1:0];
    end
  end
  assign off_we = cmd.init_wr || (cmd.try_wr && nbv && (!mev || (cd < pd)));

  tbdf_ram #(.WIDTH(tbdf_pkg::PIX_W), .DEPTH(tbdf_pkg::DEPTH)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  tbdf_ram #(.WIDTH(tbdf_pkg::OFF_W), .DEPTH(tbdf_pkg::DEPTH)) u_off_ram (
    .clk   (clk),
    .we    (off_we),
    .waddr (me),
    .wdata (off_wdata),
    .raddr (cmd.off_rd_nb ? nb_addr : me),
    .rdata (off_rbits)
  );

  assign result.out_red    = pix_rdata[7:0];
  assign result.out_green  = pix_rdata[15:8];
  assign result.out_blue   = pix_rdata[23:16];
  assign result.out_alpha  = pix_rdata[31:24];
  assign result.last_pixel = last_pixel;

endmodule

// ===== sv/texture_bleed_distance_fill_top.sv =====
// Top level of the texture bleed fill block: register port and assertions.
// Depends on tbdf_pkg, tbdf_ctrl, tbdf_datapath and the macros header.
//
//   channel   handshake                      payload
//   input     start && !busy                 item (func, in_red..in_alpha)
//   result    done (one cycle, no stall)     result (out_red..last_pixel)
//   config    psel && penable && pwrite      paddr, pwdata
//
// A fetch result appears the cycle after the fetch.
// The final load of an image with a solid pixel starts the sweep, bounded by the
// single offset store port: each pixel is seeded, then tried against its neighbors
// in each pass, and at last filled. busy is high during it.
// Reset is synchronous; the receiver cannot stall results.
`include "texture_bleed_distance_fill_top_macros.svh"
module texture_bleed_distance_fill_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tbdf_pkg::in_item_t            item,
  output tbdf_pkg::out_item_t           result,
  output logic                          done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbdf_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [tbdf_pkg::DIM_W-1:0] cfg_width, cfg_height;
  logic [7:0] cfg_thresh;
  logic wr_en, cfg_clear;
  logic [1:0] reg_idx;
  tbdf_pkg::cmd_t cmd;
  tbdf_pkg::stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_clear = wr_en && (reg_idx == tbdf_pkg::REG_WIDTH ||
                               reg_idx == tbdf_pkg::REG_HEIGHT ||
                               reg_idx == tbdf_pkg::REG_THRESH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= tbdf_pkg::WIDTH_RESET;
      cfg_height <= tbdf_pkg::HEIGHT_RESET;
      cfg_thresh <= tbdf_pkg::THRESH_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        tbdf_pkg::REG_WIDTH:  cfg_width  <= pwdata[tbdf_pkg::DIM_W-1:0];
        tbdf_pkg::REG_HEIGHT: cfg_height <= pwdata[tbdf_pkg::DIM_W-1:0];
        tbdf_pkg::REG_THRESH: cfg_thresh <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tbdf_pkg::REG_WIDTH:  prdata = 32'(cfg_width);
      tbdf_pkg::REG_HEIGHT: prdata = 32'(cfg_height);
      tbdf_pkg::REG_THRESH: prdata = 32'(cfg_thresh);
      default:              prdata = '0;
    endcase
  end

  tbdf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (item.func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tbdf_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .item       (item),
    .cfg_width  (cfg_width),
    .cfg_height (cfg_height),
    .cfg_thresh (cfg_thresh),
    .cfg_clear  (cfg_clear),
    .result     (result),
    .done       (done)
  );

  `TBDF_ASSERT_SAME(a_done_idle, done, !busy)
  `TBDF_ASSERT_NEXT(a_fetch_no_sweep, start && !busy && item.func, !busy)
  `TBDF_ASSERT_SAME(a_sweep_after_load, $rose(busy), $past(start && !item.func))

endmodule
